// ----- design/dpbp_pkg.sv -----
// Shared types, constants and register codes of the depth pixel back-projection block.
// No dependencies; every other file of the block imports this package.
package dpbp_pkg;

  localparam int MAX_WIDTH   = 4096;
  localparam int MAX_HEIGHT  = 4096;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int PIX_W       = 16;
  localparam int CNT_W       = 25;
  localparam int COORD_W     = 24;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 3;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANGE_MIN  = 3'd0,
    REG_RANGE_MAX  = 3'd1,
    REG_Z_GAIN     = 3'd2,
    REG_X_GAIN     = 3'd3,
    REG_Y_GAIN     = 3'd4,
    REG_CENTER_X   = 3'd5,
    REG_CENTER_Y   = 3'd6,
    REG_DECIMATION = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] depth_lo;
    logic [15:0] depth_hi;
    logic [23:0] z_gain;
    logic [31:0] x_gain;
    logic [31:0] y_gain;
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [7:0]  col_stride;
    logic [7:0]  row_stride;
  } cfg_t;

  // One classified pixel on its way from the front to the back.
  typedef struct packed {
    logic             point_valid;
    logic [PIX_W-1:0] raw;
    logic [15:0]      x_mag;
    logic             x_neg;
    logic [15:0]      y_mag;
    logic             y_neg;
    logic             frame_done;
    logic [CNT_W-1:0] point_count;
  } cmd_t;

endpackage

// ----- design/dpbp_front.sv -----
// Front end: raster position tracking, decimation, range gating and point counting.
// Depends on dpbp_pkg; feeds classified beats into dpbp_queue.
module dpbp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  dpbp_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [15:0]         in_depth_raw,
  input  logic                in_row_end,
  input  logic                in_frame_end,
  input  logic                q_full,
  output logic                push,
  output dpbp_pkg::cmd_t      cmd
);
  import dpbp_pkg::*;

  logic [COL_W-1:0] col_idx_r, col_idx_nxt;
  logic [ROW_W-1:0] row_idx_r, row_idx_nxt;
  logic [7:0]       col_phase_r, col_phase_nxt;
  logic [7:0]       row_phase_r, row_phase_nxt;
  logic [CNT_W-1:0] kept_r, kept_nxt;

  logic             accept;
  logic             have_info;
  logic             kept;
  logic [15:0]      col_pos;
  logic [15:0]      row_pos;

  function automatic logic [7:0] next_phase(input logic [7:0] phase, input logic [7:0] step);
    logic [7:0] step_eff;
    logic [8:0] inc;
    step_eff = (step == 8'd0) ? 8'd1 : step;
    inc      = {1'b0, phase} + 9'd1;
    return (inc >= {1'b0, step_eff}) ? 8'd0 : inc[7:0];
  endfunction

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign have_info = (cfg.x_gain != 32'd0) && (cfg.y_gain != 32'd0);
  assign kept      = have_info && (col_phase_r == 8'd0) && (row_phase_r == 8'd0) &&
                     (in_depth_raw != 16'd0) && (in_depth_raw >= cfg.depth_lo) &&
                     (in_depth_raw <= cfg.depth_hi);

  // Pixel position in Q12.4, to be compared with the principal point.
  assign col_pos = 16'({col_idx_r, 4'b0000});
  assign row_pos = 16'({row_idx_r, 4'b0000});

  always_comb begin
    kept_nxt = kept_r;
    if (accept && kept && (kept_r != COUNT_MAX)) begin
      kept_nxt = kept_r + 1'b1;
    end
  end

  always_comb begin
    cmd.point_valid = kept;
    cmd.raw         = kept ? in_depth_raw : '0;
    cmd.x_neg       = col_pos < cfg.center_x;
    cmd.x_mag       = cmd.x_neg ? (cfg.center_x - col_pos) : (col_pos - cfg.center_x);
    cmd.y_neg       = row_pos < cfg.center_y;
    cmd.y_mag       = cmd.y_neg ? (cfg.center_y - row_pos) : (row_pos - cfg.center_y);
    cmd.frame_done  = in_frame_end;
    cmd.point_count = in_frame_end ? kept_nxt : '0;
  end

  assign push = accept && (kept || (in_frame_end && have_info));

  always_comb begin
    col_idx_nxt   = col_idx_r;
    row_idx_nxt   = row_idx_r;
    col_phase_nxt = col_phase_r;
    row_phase_nxt = row_phase_r;
    if (in_frame_end) begin
      col_idx_nxt   = '0;
      row_idx_nxt   = '0;
      col_phase_nxt = '0;
      row_phase_nxt = '0;
    end else if (in_row_end) begin
      col_idx_nxt   = '0;
      col_phase_nxt = '0;
      if (row_idx_r < ROW_W'(MAX_HEIGHT - 1)) begin
        row_idx_nxt = row_idx_r + 1'b1;
      end
      row_phase_nxt = next_phase(row_phase_r, cfg.row_stride);
    end else begin
      if (col_idx_r < COL_W'(MAX_WIDTH - 1)) begin
        col_idx_nxt = col_idx_r + 1'b1;
      end
      col_phase_nxt = next_phase(col_phase_r, cfg.col_stride);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_idx_r   <= '0;
      row_idx_r   <= '0;
      col_phase_r <= '0;
      row_phase_r <= '0;
      kept_r      <= '0;
    end else if (accept) begin
      col_idx_r   <= col_idx_nxt;
      row_idx_r   <= row_idx_nxt;
      col_phase_r <= col_phase_nxt;
      row_phase_r <= row_phase_nxt;
      kept_r      <= in_frame_end ? '0 : kept_nxt;
    end
  end

`ifndef SYNTHESIS
  a_push_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> accept)
    else $error("front pushed without an accepted beat");

  a_frame_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_frame_end) |=> (kept_r == '0) && (col_idx_r == '0) && (row_idx_r == '0))
    else $error("frame end did not clear position and count");

  a_count_only_at_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !cmd.frame_done) |-> (cmd.point_count == '0))
    else $error("point count set on a beat that does not close a frame");

  a_no_point_without_gains: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> have_info)
    else $error("beat pushed while intrinsics are missing");
`endif

endmodule

// ----- design/dpbp_queue.sv -----
// Short first-in first-out queue of classified beats between front and back.
// Depends on dpbp_pkg for the beat type and queue depth.
module dpbp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dpbp_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output dpbp_pkg::cmd_t head_cmd
);
  import dpbp_pkg::*;

  cmd_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   fill_r, fill_nxt;

  assign full       = (fill_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (fill_r != '0);
  assign head_cmd   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

`ifndef SYNTHESIS
  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= (QPTR_W+1)'(QUEUE_DEPTH))
    else $error("queue fill level beyond its depth");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from an empty queue");
`endif

endmodule

// ----- design/dpbp_back.sv -----
// Back end: three-stage projection pipeline (products, gain products, round and saturate).
// Depends on dpbp_pkg; takes beats from dpbp_queue and holds the result register.
module dpbp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  dpbp_pkg::cfg_t      cfg,
  input  logic                head_valid,
  input  dpbp_pkg::cmd_t      head_cmd,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_point_valid,
  output logic signed [23:0]  out_x_pos,
  output logic signed [23:0]  out_y_pos,
  output logic [23:0]         out_z_pos,
  output logic                out_frame_done,
  output logic [24:0]         out_point_count
);
  import dpbp_pkg::*;

  // Stage 1: magnitude times raw depth, raw depth times z gain.
  logic             s1_valid_r, s1_valid_nxt;
  logic [31:0]      s1_xp_r, s1_yp_r;
  logic [39:0]      s1_zp_r;
  logic             s1_x_neg_r, s1_y_neg_r, s1_pv_r, s1_fd_r;
  logic [CNT_W-1:0] s1_cnt_r;

  // Stage 2: full products with the lateral gains, z already rounded.
  logic             s2_valid_r, s2_valid_nxt;
  logic [63:0]      s2_xp_r, s2_yp_r;
  logic [23:0]      s2_z_r, s2_z_nxt;
  logic             s2_x_neg_r, s2_y_neg_r, s2_pv_r, s2_fd_r;
  logic [CNT_W-1:0] s2_cnt_r;

  logic             out_valid_r, out_valid_nxt;
  logic             out_pv_r, out_fd_r;
  logic [23:0]      out_x_r, out_y_r, out_z_r;
  logic [CNT_W-1:0] out_cnt_r;

  logic             out_free;
  logic             s2_ready;
  logic             s1_ready;
  logic [32:0]      z_round;

  // Round half away from zero on the magnitude, then saturate and apply the sign.
  function automatic logic [23:0] round_sat(input logic [63:0] prod, input logic neg);
    logic [63:0] sum;
    logic [43:0] q;
    sum = prod + 64'd524288;
    q   = sum[63:20];
    if (neg) begin
      return (q > 44'd8388608) ? 24'h800000 : (24'd0 - q[23:0]);
    end
    return (q > 44'd8388607) ? 24'h7FFFFF : q[23:0];
  endfunction

  assign out_free = !out_valid_r || out_ready;
  assign s2_ready = !s2_valid_r || out_free;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign pop      = head_valid && s1_ready;

  assign z_round  = 33'({1'b0, s1_zp_r} + 41'd128 >> 8);
  assign s2_z_nxt = (z_round > 33'h0FFFFFF) ? 24'hFFFFFF : z_round[23:0];

  always_comb begin
    s1_valid_nxt  = s1_ready ? head_valid : s1_valid_r;
    s2_valid_nxt  = s2_ready ? s1_valid_r : s2_valid_r;
    out_valid_nxt = out_free ? s2_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_xp_r    <= {16'd0, head_cmd.x_mag} * {16'd0, head_cmd.raw};
      s1_yp_r    <= {16'd0, head_cmd.y_mag} * {16'd0, head_cmd.raw};
      s1_zp_r    <= {24'd0, head_cmd.raw} * {16'd0, cfg.z_gain};
      s1_x_neg_r <= head_cmd.x_neg;
      s1_y_neg_r <= head_cmd.y_neg;
      s1_pv_r    <= head_cmd.point_valid;
      s1_fd_r    <= head_cmd.frame_done;
      s1_cnt_r   <= head_cmd.point_count;
    end
    if (s2_ready) begin
      s2_xp_r    <= {32'd0, s1_xp_r} * {32'd0, cfg.x_gain};
      s2_yp_r    <= {32'd0, s1_yp_r} * {32'd0, cfg.y_gain};
      s2_z_r     <= s2_z_nxt;
      s2_x_neg_r <= s1_x_neg_r;
      s2_y_neg_r <= s1_y_neg_r;
      s2_pv_r    <= s1_pv_r;
      s2_fd_r    <= s1_fd_r;
      s2_cnt_r   <= s1_cnt_r;
    end
    if (out_free) begin
      out_x_r   <= round_sat(s2_xp_r, s2_x_neg_r);
      out_y_r   <= round_sat(s2_yp_r, s2_y_neg_r);
      out_z_r   <= s2_z_r;
      out_pv_r  <= s2_pv_r;
      out_fd_r  <= s2_fd_r;
      out_cnt_r <= s2_cnt_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_point_valid = out_pv_r;
  assign out_x_pos       = out_x_r;
  assign out_y_pos       = out_y_r;
  assign out_z_pos       = out_z_r;
  assign out_frame_done  = out_fd_r;
  assign out_point_count = out_cnt_r;

`ifndef SYNTHESIS
  a_s1_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_ready) |=> s1_valid_r)
    else $error("stage one dropped a beat while stalled");

  a_empty_point_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_pv_r) |-> (out_x_r == '0) && (out_y_r == '0) && (out_z_r == '0))
    else $error("coordinates nonzero on a result without a point");

  a_result_has_purpose: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_pv_r || out_fd_r))
    else $error("result carries neither a point nor a frame close");

  a_pop_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (!s1_valid_r || s2_ready))
    else $error("pop into an occupied stage one");
`endif

endmodule

// ----- design/depth_pixel_backprojection.sv -----
// Depth pixel back-projection: a raster of depth pixels in, pinhole points out.
// Top level; holds the configuration registers and ties dpbp_front, dpbp_queue and dpbp_back.
//
// Usage:
//   Input channel (in_valid/in_ready): one depth pixel per beat with row and frame end marks.
//   Output channel (out_valid/out_ready): one result per kept pixel; the frame end pixel,
//   kept or not, gives one result that carries the frame's point count. Nothing comes out
//   while either lateral gain is zero.
//   Configuration: cfg_we writes cfg_wdata into register cfg_index; write only while no
//   beat is in flight.
// Path: an accepted pixel passes the queue, the multiply stage, the gain multiply stage and
//   the rounding into the output register.
// Throughput: one pixel per cycle while out_ready holds high; the front classifies in the
//   accept cycle and every back stage moves one beat per cycle unless it is stalled.
// Reset: synchronous, active low; raster position, phases and point count clear and the
//   configuration returns to its defaults.
// Stall: when out_ready is low the output register, both multiply stages and the four-entry
//   queue fill in turn; in_ready drops only when the queue is full.
module depth_pixel_backprojection (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [dpbp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dpbp_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [15:0]                           in_depth_raw,
  input  logic                                  in_row_end,
  input  logic                                  in_frame_end,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_point_valid,
  output logic signed [23:0]                    out_x_pos,
  output logic signed [23:0]                    out_y_pos,
  output logic [23:0]                           out_z_pos,
  output logic                                  out_frame_done,
  output logic [24:0]                           out_point_count
);
  import dpbp_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic push, q_full, pop, head_valid;
  cmd_t push_cmd, head_cmd;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_RANGE_MIN:  cfg_nxt.depth_lo  = cfg_wdata[15:0];
        REG_RANGE_MAX:  cfg_nxt.depth_hi  = cfg_wdata[15:0];
        REG_Z_GAIN:     cfg_nxt.z_gain    = cfg_wdata[23:0];
        REG_X_GAIN:     cfg_nxt.x_gain    = cfg_wdata;
        REG_Y_GAIN:     cfg_nxt.y_gain    = cfg_wdata;
        REG_CENTER_X:   cfg_nxt.center_x  = cfg_wdata[15:0];
        REG_CENTER_Y:   cfg_nxt.center_y  = cfg_wdata[15:0];
        REG_DECIMATION: begin
          cfg_nxt.col_stride = cfg_wdata[7:0];
          cfg_nxt.row_stride = cfg_wdata[15:8];
        end
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.depth_lo   <= 16'd100;
      cfg_r.depth_hi   <= 16'd5000;
      cfg_r.z_gain     <= 24'd16777;
      cfg_r.x_gain     <= 32'd0;
      cfg_r.y_gain     <= 32'd0;
      cfg_r.center_x   <= 16'd0;
      cfg_r.center_y   <= 16'd0;
      cfg_r.col_stride <= 8'd1;
      cfg_r.row_stride <= 8'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  dpbp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_depth_raw (in_depth_raw),
    .in_row_end   (in_row_end),
    .in_frame_end (in_frame_end),
    .q_full       (q_full),
    .push         (push),
    .cmd          (push_cmd)
  );

  dpbp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  dpbp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .head_valid      (head_valid),
    .head_cmd        (head_cmd),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_point_valid (out_point_valid),
    .out_x_pos       (out_x_pos),
    .out_y_pos       (out_y_pos),
    .out_z_pos       (out_z_pos),
    .out_frame_done  (out_frame_done),
    .out_point_count (out_point_count)
  );

endmodule

// ----- bench/depth_pixel_backprojection_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for depth_pixel_backprojection: directed and random raster streams.
// A scoreboard class predicts each point and frame-done beat. Needs dpbp_pkg and the RTL.
module depth_pixel_backprojection_tb;
  import dpbp_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int DRAIN_CYCLES  = 12;
  localparam int HOLD_CYCLES   = 120;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_PIXELS  = 44;

  typedef struct {
    logic [15:0] depth_lo;
    logic [15:0] depth_hi;
    logic [23:0] z_gain;
    logic [31:0] x_gain;
    logic [31:0] y_gain;
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [7:0]  col_stride;
    logic [7:0]  row_stride;
  } camera_cfg_t;

  typedef struct {
    logic        point_valid;
    logic [23:0] x_pos;
    logic [23:0] y_pos;
    logic [23:0] z_pos;
    logic        frame_done;
    logic [24:0] point_count;
  } point_beat_t;

  class cloud_scoreboard;
    camera_cfg_t cfg;
    int unsigned col_idx = 0;
    int unsigned row_idx = 0;
    int unsigned col_phase = 0;
    int unsigned row_phase = 0;
    logic [24:0] kept_points = '0;
    point_beat_t pending_points[$];
    int          mismatches = 0;

    function void load_config(camera_cfg_t c);
      cfg = c;
    endfunction

    function int pending_count();
      return pending_points.size();
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("%0t mismatch: %s", $time, msg);
    endtask

    function int unsigned advance_phase(int unsigned phase, int unsigned step);
      return (phase + 1 >= step) ? 0 : phase + 1;
    endfunction

    // Lateral coordinate: (pos*16 - center) * raw * gain / 2^20, rounded half away
    // from zero on the magnitude, then saturated to signed 24 bits.
    function logic [23:0] project_axis(int unsigned pos, logic [15:0] center,
                                       logic [15:0] raw, logic [31:0] gain);
      logic [16:0] scaled_pos;
      logic [16:0] mag;
      logic [65:0] prod;
      logic [65:0] rounded;
      logic        neg;
      scaled_pos = 17'(pos << 4);
      neg = scaled_pos < center;
      mag = neg ? center - scaled_pos : scaled_pos - center;
      prod = mag * raw * gain;
      rounded = (prod + 66'd524288) >> 20;
      if (neg) begin
        if (rounded > 66'd8388608) rounded = 66'd8388608;
        return ~rounded[23:0] + 24'd1;
      end
      if (rounded > 66'd8388607) rounded = 66'd8388607;
      return rounded[23:0];
    endfunction

    function void note_pixel(logic [15:0] raw, logic row_end, logic frame_end);
      int unsigned col_stride;
      int unsigned row_stride;
      logic        have_gains;
      logic        kept;
      logic [47:0] z_full;
      point_beat_t beat;
      col_stride = (cfg.col_stride == 0) ? 1 : cfg.col_stride;
      row_stride = (cfg.row_stride == 0) ? 1 : cfg.row_stride;
      have_gains = (cfg.x_gain != 0) && (cfg.y_gain != 0);
      kept = have_gains && col_phase == 0 && row_phase == 0 && raw != 0 &&
             raw >= cfg.depth_lo && raw <= cfg.depth_hi;
      beat = '{default: '0};
      if (kept) begin
        z_full = (raw * cfg.z_gain + 48'd128) >> 8;
        beat.point_valid = 1'b1;
        beat.z_pos = (z_full > 48'hFFFFFF) ? 24'hFFFFFF : z_full[23:0];
        beat.x_pos = project_axis(col_idx, cfg.center_x, raw, cfg.x_gain);
        beat.y_pos = project_axis(row_idx, cfg.center_y, raw, cfg.y_gain);
        if (kept_points != COUNT_MAX) kept_points = kept_points + 25'd1;
      end
      // Without both lateral gains even the frame end stays silent.
      if (kept || (frame_end && have_gains)) begin
        beat.frame_done = frame_end;
        beat.point_count = frame_end ? kept_points : '0;
        pending_points.push_back(beat);
      end
      if (frame_end) begin
        col_idx = 0;
        row_idx = 0;
        col_phase = 0;
        row_phase = 0;
        kept_points = '0;
      end else if (row_end) begin
        col_idx = 0;
        col_phase = 0;
        if (row_idx < MAX_HEIGHT - 1) row_idx++;
        row_phase = advance_phase(row_phase, row_stride);
      end else begin
        if (col_idx < MAX_WIDTH - 1) col_idx++;
        col_phase = advance_phase(col_phase, col_stride);
      end
    endfunction

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task check_point(point_beat_t got);
      point_beat_t want;
      if (pending_points.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing expected (point_valid %0b)",
                                  got.point_valid));
        return;
      end
      want = pending_points.pop_front();
      compare_field("point_valid", got.point_valid, want.point_valid);
      compare_field("x_pos", got.x_pos, want.x_pos);
      compare_field("y_pos", got.y_pos, want.y_pos);
      compare_field("z_pos", got.z_pos, want.z_pos);
      compare_field("frame_done", got.frame_done, want.frame_done);
      compare_field("point_count", got.point_count, want.point_count);
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic [15:0]           in_depth_raw;
  logic                  in_row_end;
  logic                  in_frame_end;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_point_valid;
  logic signed [23:0]    out_x_pos;
  logic signed [23:0]    out_y_pos;
  logic [23:0]           out_z_pos;
  logic                  out_frame_done;
  logic [24:0]           out_point_count;

  cloud_scoreboard sb;
  camera_cfg_t     cur_cfg;
  bit              tx_steady = 1'b0;
  bit              rx_steady = 1'b0;
  bit              hold_output = 1'b0;
  int              walk_col = 0;
  int              walk_row = 0;
  int              walk_width = 0;
  int              walk_height = 0;

  depth_pixel_backprojection u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_depth_raw    (in_depth_raw),
    .in_row_end      (in_row_end),
    .in_frame_end    (in_frame_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_point_valid (out_point_valid),
    .out_x_pos       (out_x_pos),
    .out_y_pos       (out_y_pos),
    .out_z_pos       (out_z_pos),
    .out_frame_done  (out_frame_done),
    .out_point_count (out_point_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[depth_pixel_backprojection] ERROR");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // Mostly typical values, with the zero and all-ones extremes now and then.
  function automatic logic [31:0] pick_value(logic [31:0] lo, logic [31:0] hi,
                                             logic [31:0] top);
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return top;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  function automatic camera_cfg_t make_cfg(logic [15:0] depth_lo, logic [15:0] depth_hi,
                                           logic [23:0] z_gain, logic [31:0] x_gain,
                                           logic [31:0] y_gain, logic [15:0] center_x,
                                           logic [15:0] center_y, logic [15:0] steps);
    camera_cfg_t c;
    c.depth_lo = depth_lo;
    c.depth_hi = depth_hi;
    c.z_gain = z_gain;
    c.x_gain = x_gain;
    c.y_gain = y_gain;
    c.center_x = center_x;
    c.center_y = center_y;
    c.col_stride = steps[7:0];
    c.row_stride = steps[15:8];
    return c;
  endfunction

  function automatic camera_cfg_t random_cfg();
    camera_cfg_t c;
    c.depth_lo = 16'(pick_value(0, 300, 32'hFFFF));
    c.depth_hi = 16'(pick_value(2000, 12000, 32'hFFFF));
    c.z_gain = 24'(pick_value(1000, 70000, 32'hFFFFFF));
    c.x_gain = pick_value(1000, 400000, 32'hFFFFFFFF);
    c.y_gain = pick_value(1000, 400000, 32'hFFFFFFFF);
    c.center_x = 16'(pick_value(0, 200, 32'hFFFF));
    c.center_y = 16'(pick_value(0, 200, 32'hFFFF));
    c.col_stride = 8'(pick_value(1, 3, 32'hFF));
    c.row_stride = 8'(pick_value(1, 3, 32'hFF));
    return c;
  endfunction

  // Depths fall mostly inside the range window; edges, values just past them, zero and random values mix in.
  function automatic logic [15:0] pick_depth();
    case ($urandom_range(0, 15))
      0: return 16'd0;
      1: return 16'($urandom);
      2: return cur_cfg.depth_lo;
      3: return cur_cfg.depth_hi;
      4: return cur_cfg.depth_lo - 16'd1;
      5: return cur_cfg.depth_hi + 16'd1;
      default: begin
        if (cur_cfg.depth_lo <= cur_cfg.depth_hi)
          return 16'($urandom_range(cur_cfg.depth_lo, cur_cfg.depth_hi));
        return 16'($urandom);
      end
    endcase
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic apply_config(input camera_cfg_t c);
    write_reg(REG_RANGE_MIN, 32'(c.depth_lo));
    write_reg(REG_RANGE_MAX, 32'(c.depth_hi));
    write_reg(REG_Z_GAIN, 32'(c.z_gain));
    write_reg(REG_X_GAIN, c.x_gain);
    write_reg(REG_Y_GAIN, c.y_gain);
    write_reg(REG_CENTER_X, 32'(c.center_x));
    write_reg(REG_CENTER_Y, 32'(c.center_y));
    write_reg(REG_DECIMATION, {16'd0, c.row_stride, c.col_stride});
    cfg_we <= 1'b0;
    cur_cfg = c;
    sb.load_config(c);
  endtask

  task automatic send_pixel(input logic [15:0] raw, input logic row_end,
                            input logic frame_end);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_depth_raw <= raw;
    in_row_end <= row_end;
    in_frame_end <= frame_end;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_pixel(raw, row_end, frame_end);
  endtask

  // Walks well-formed frames of random size; a few beats carry stray row or frame marks.
  task automatic send_random_pixels(input int count);
    logic        row_end;
    logic        frame_end;
    logic [15:0] raw;
    repeat (count) begin
      if (walk_width == 0) begin
        walk_width = $urandom_range(1, 10);
        walk_height = $urandom_range(1, 6);
        walk_col = 0;
        walk_row = 0;
      end
      raw = pick_depth();
      row_end = walk_col >= walk_width - 1;
      frame_end = row_end && walk_row >= walk_height - 1;
      if ($urandom_range(0, 19) == 0) begin
        row_end = $urandom_range(0, 1);
        frame_end = $urandom_range(0, 3) == 0;
      end
      send_pixel(raw, row_end, frame_end);
      if (frame_end) begin
        walk_width = 0;
      end else if (row_end) begin
        walk_col = 0;
        walk_row++;
      end else begin
        walk_col++;
      end
    end
  endtask

  // A dropped pixel leaves no beat behind, so the tail of the pipeline gets extra cycles.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : result_sink
    point_beat_t got;
    int          stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got.point_valid = out_point_valid;
        got.x_pos = out_x_pos;
        got.y_pos = out_y_pos;
        got.z_pos = out_z_pos;
        got.frame_done = out_frame_done;
        got.point_count = out_point_count;
        sb.check_point(got);
      end
      if (hold_output) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output = 1'b0;
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!rx_steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin : stimulus
    in_valid <= 1'b0;
    in_depth_raw <= 16'd0;
    in_row_end <= 1'b0;
    in_frame_end <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_RANGE_MIN;
    cfg_wdata <= '0;
    rst_n <= 1'b0;
    cur_cfg = make_cfg(16'd100, 16'd5000, 24'd16777, 32'd0, 32'd0, 16'd0, 16'd0, 16'h0101);
    sb = new();
    sb.load_config(cur_cfg);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults have no lateral gains, so nothing may come out.
    send_pixel(16'd1000, 1'b0, 1'b0);
    send_pixel(16'd2000, 1'b1, 1'b0);
    send_pixel(16'd300, 1'b0, 1'b0);
    send_pixel(16'd500, 1'b0, 1'b1);
    wait_idle();

    // Zero steps act as one; raw extremes and the zero pixel.
    apply_config(make_cfg(16'd0, 16'hFFFF, 24'd16777, 32'd7158, 32'd7158, 16'd32, 16'd16,
                          16'h0000));
    send_pixel(16'd0, 1'b0, 1'b0);
    send_pixel(16'hFFFF, 1'b0, 1'b0);
    send_pixel(16'd1, 1'b0, 1'b0);
    send_pixel(16'd4660, 1'b1, 1'b0);
    send_pixel(16'd1234, 1'b0, 1'b0);
    send_pixel(16'd3000, 1'b0, 1'b1);
    wait_idle();

    // Leave both phases off the grid, then shrink the steps in the middle of the frame.
    apply_config(make_cfg(16'd0, 16'hFFFF, 24'd16777, 32'd7158, 32'd7158, 16'd32, 16'd16,
                          {8'd3, 8'd4}));
    send_pixel(16'd100, 1'b1, 1'b0);
    send_pixel(16'd200, 1'b0, 1'b0);
    send_pixel(16'd300, 1'b0, 1'b0);
    send_pixel(16'd400, 1'b0, 1'b0);
    wait_idle();
    apply_config(make_cfg(16'd0, 16'hFFFF, 24'd16777, 32'd7158, 32'd7158, 16'd32, 16'd16,
                          {8'd1, 8'd2}));
    send_pixel(16'd500, 1'b0, 1'b0);
    send_pixel(16'd600, 1'b0, 1'b0);
    send_pixel(16'd700, 1'b1, 1'b0);
    send_pixel(16'd800, 1'b0, 1'b0);
    send_pixel(16'd900, 1'b0, 1'b1);
    wait_idle();

    // All gains at full scale: z saturates, x saturates negative and y, on the second row, positive.
    apply_config(make_cfg(16'd0, 16'hFFFF, 24'hFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF,
                          16'd0, 16'h0101));
    send_pixel(16'hFFFF, 1'b0, 1'b0);
    send_pixel(16'hFFFF, 1'b1, 1'b0);
    send_pixel(16'hFFFF, 1'b0, 1'b1);
    wait_idle();

    // Only the vertical gain is missing.
    apply_config(make_cfg(16'd100, 16'd5000, 24'd16777, 32'd1, 32'd0, 16'd0, 16'd0,
                          16'h0101));
    send_pixel(16'd1000, 1'b0, 1'b0);
    send_pixel(16'd2000, 1'b1, 1'b0);
    send_pixel(16'd1000, 1'b0, 1'b1);
    wait_idle();

    // Inverted range window keeps nothing, yet the frame end reports a zero count.
    apply_config(make_cfg(16'd6000, 16'd10, 24'd16777, 32'd7158, 32'd7158, 16'd0, 16'd0,
                          16'h0101));
    send_pixel(16'd5, 1'b0, 1'b0);
    send_pixel(16'd8000, 1'b0, 1'b0);
    send_pixel(16'd7000, 1'b0, 1'b1);
    wait_idle();

    // Back pressure: the sink holds off while beats keep coming, so in_ready must drop.
    apply_config(make_cfg(16'd1, 16'hFFFF, 24'd16777, 32'd9000, 32'd9000, 16'd80, 16'd40,
                          16'h0101));
    tx_steady = 1'b1;
    hold_output = 1'b1;
    for (int i = 0; i < 24; i++) send_pixel(pick_depth(), i % 6 == 5, i == 23);
    tx_steady = 1'b0;
    wait_idle();

    // Random settings; a frame may run on across a setting change.
    repeat (RANDOM_PHASES) begin
      apply_config(random_cfg());
      tx_steady = $urandom_range(0, 3) == 0;
      rx_steady = $urandom_range(0, 3) == 0;
      send_random_pixels(PHASE_PIXELS);
      wait_idle();
    end

    // Expectations that never arrive keep wait_idle looping until the watchdog fires.
    if (sb.mismatches == 0) begin
      $display("[depth_pixel_backprojection] OK");
    end else begin
      $display("[depth_pixel_backprojection] ERROR");
    end
    $finish;
  end

endmodule
